[hdl/attitude_block_average_motion_unit_defines.svh]
// assertion macros for the attitude block averager
`ifndef ATTITUDE_BLOCK_AVERAGE_MOTION_UNIT_DEFINES_SVH
`define ATTITUDE_BLOCK_AVERAGE_MOTION_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define ABAM_ASSERT_ALWAYS(label, clock, reset, expr, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (expr)) \
    else $error(msg);

// same-cycle implication
`define ABAM_ASSERT_SAME(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABAM_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/abam_pkg.sv]
`timescale 1ns / 1ps

package abam_pkg;

  localparam int BLOCK_SAMPLES_DEF = 16;
  localparam int ANGLE_W           = 9;
  localparam int MOTION_W          = 32;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [ANGLE_W-1:0]        angle_mag_t;
  typedef logic [MOTION_W-1:0]       motion_t;

endpackage

[hdl/attitude_block_average_motion_unit.sv]
// data path: input register, then result register, to the result side
// throughput: one word per cycle while not stalled; an input register and a
// result register part the two sides, so one word is still taken while a result
// waits; rate is set by the combinational accumulate and reciprocal-multiply divide
// reset: synchronous, clears sums, count, movement totals, averages and both stages
`timescale 1ns / 1ps

`include "attitude_block_average_motion_unit_defines.svh"

module attitude_block_average_motion_unit
  import abam_pkg::*;
#(
  parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  angle_t  roll_angle,
  input  angle_t  pitch_angle,
  input  angle_t  yaw_angle,
  output logic    result_valid,
  input  logic    result_stall,
  output logic    average_valid,
  output angle_t  average_roll,
  output angle_t  average_pitch,
  output angle_t  average_yaw,
  output motion_t roll_movement,
  output motion_t pitch_movement
);

  localparam int     CNT_W   = $clog2(BLOCK_SAMPLES + 1);
  localparam int     SHIFT_L = $clog2(BLOCK_SAMPLES);
  localparam int     SUM_W   = ANGLE_W + SHIFT_L;
  localparam int     MAG_W   = SUM_W;
  localparam int     RECIP_S = MAG_W + SHIFT_L;
  localparam int     RECIP_W = MAG_W + 1;
  localparam int     PROD_W  = MAG_W + RECIP_W;
  localparam longint RECIP   =
    ((longint'(1) << RECIP_S) + longint'(BLOCK_SAMPLES) - 1) / longint'(BLOCK_SAMPLES);

  // sum over block length, truncated toward zero, by reciprocal multiply
  function automatic angle_t block_mean(input logic signed [SUM_W-1:0] s);
    logic [MAG_W-1:0]   m;
    logic [PROD_W-1:0]  p;
    logic [ANGLE_W:0]   q;
    m = $unsigned(s);
    if (s[SUM_W-1]) begin
      m = ~m + 1'b1;
    end
    p = PROD_W'(m) * PROD_W'(RECIP_W'($unsigned(RECIP)));
    q = (ANGLE_W+1)'(p >> RECIP_S);
    if (s[SUM_W-1]) begin
      q = ~q + 1'b1;
    end
    return $signed(q[ANGLE_W-1:0]);
  endfunction

  function automatic angle_mag_t magnitude(input angle_t a);
    angle_mag_t m;
    m = $unsigned(a);
    if (a[ANGLE_W-1]) begin
      m = ~m + 1'b1;
    end
    return m;
  endfunction

  function automatic motion_t motion_add(input motion_t total, input angle_mag_t now_mag,
                                         input angle_mag_t prior_mag);
    angle_mag_t        d;
    logic [MOTION_W:0] s;
    d = (now_mag >= prior_mag) ? (now_mag - prior_mag) : (prior_mag - now_mag);
    s = {1'b0, total} + (MOTION_W+1)'(d);
    return s[MOTION_W] ? '1 : s[MOTION_W-1:0];
  endfunction

  // input stage
  logic   s1_valid;
  angle_t s1_roll;
  angle_t s1_pitch;
  angle_t s1_yaw;

  // block state
  logic [CNT_W-1:0]        sample_count;
  logic signed [SUM_W-1:0] roll_sum;
  logic signed [SUM_W-1:0] pitch_sum;
  logic signed [SUM_W-1:0] yaw_sum;
  angle_mag_t              prior_abs_roll;
  angle_mag_t              prior_abs_pitch;

  logic                    sample_count_next_en;
  logic [CNT_W-1:0]        sample_count_next;
  logic signed [SUM_W-1:0] roll_sum_next;
  logic signed [SUM_W-1:0] pitch_sum_next;
  logic signed [SUM_W-1:0] yaw_sum_next;
  angle_mag_t              prior_abs_roll_next;
  angle_mag_t              prior_abs_pitch_next;
  angle_t                  average_roll_next;
  angle_t                  average_pitch_next;
  angle_t                  average_yaw_next;
  motion_t                 roll_movement_next;
  motion_t                 pitch_movement_next;

  logic accept;
  logic s1_move;
  logic block_full;

  assign s1_move      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;
  assign block_full   = (sample_count == CNT_W'(BLOCK_SAMPLES));

  always_comb begin
    angle_mag_t ar;
    angle_mag_t ap;
    ar = magnitude(s1_roll);
    ap = magnitude(s1_pitch);
    sample_count_next_en = s1_move;
    sample_count_next    = sample_count + 1'b1;
    roll_sum_next        = roll_sum + SUM_W'(s1_roll);
    pitch_sum_next       = pitch_sum + SUM_W'(s1_pitch);
    yaw_sum_next         = yaw_sum + SUM_W'(s1_yaw);
    prior_abs_roll_next  = ar;
    prior_abs_pitch_next = ap;
    roll_movement_next   = motion_add(roll_movement, ar, prior_abs_roll);
    pitch_movement_next  = motion_add(pitch_movement, ap, prior_abs_pitch);
    average_roll_next    = average_roll;
    average_pitch_next   = average_pitch;
    average_yaw_next     = average_yaw;
    if (block_full) begin
      // division word: sample dropped, averages latched, block restarts
      sample_count_next    = '0;
      roll_sum_next        = '0;
      pitch_sum_next       = '0;
      yaw_sum_next         = '0;
      prior_abs_roll_next  = prior_abs_roll;
      prior_abs_pitch_next = prior_abs_pitch;
      roll_movement_next   = roll_movement;
      pitch_movement_next  = pitch_movement;
      average_roll_next    = block_mean(roll_sum);
      average_pitch_next   = block_mean(pitch_sum);
      average_yaw_next     = block_mean(yaw_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_roll  <= roll_angle;
      s1_pitch <= pitch_angle;
      s1_yaw   <= yaw_angle;
    end
    if (rst) begin
      s1_valid        <= 1'b0;
      result_valid    <= 1'b0;
      average_valid   <= 1'b0;
      sample_count    <= '0;
      roll_sum        <= '0;
      pitch_sum       <= '0;
      yaw_sum         <= '0;
      prior_abs_roll  <= '0;
      prior_abs_pitch <= '0;
      roll_movement   <= '0;
      pitch_movement  <= '0;
      average_roll    <= '0;
      average_pitch   <= '0;
      average_yaw     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (sample_count_next_en) begin
        average_valid   <= block_full;
        sample_count    <= sample_count_next;
        roll_sum        <= roll_sum_next;
        pitch_sum       <= pitch_sum_next;
        yaw_sum         <= yaw_sum_next;
        prior_abs_roll  <= prior_abs_roll_next;
        prior_abs_pitch <= prior_abs_pitch_next;
        roll_movement   <= roll_movement_next;
        pitch_movement  <= pitch_movement_next;
        average_roll    <= average_roll_next;
        average_pitch   <= average_pitch_next;
        average_yaw     <= average_yaw_next;
      end
    end
  end

  `ABAM_ASSERT_ALWAYS(a_count_range, clk, rst, sample_count <= CNT_W'(BLOCK_SAMPLES), "sample count beyond block length")
  `ABAM_ASSERT_SAME(a_stall_full, clk, rst, sample_stall, s1_valid && result_valid, "stall with a free stage")
  `ABAM_ASSERT_NEXT(a_div_clears, clk, rst, s1_move && block_full, average_valid && sample_count == '0 && roll_sum == '0 && yaw_sum == '0, "division word did not restart block")
  `ABAM_ASSERT_NEXT(a_acc_holds, clk, rst, s1_move && !block_full, !average_valid && $stable(average_roll) && $stable(average_pitch) && $stable(average_yaw), "averages moved on a sample word")
  `ABAM_ASSERT_NEXT(a_motion_grows, clk, rst, !rst, roll_movement >= $past(roll_movement) && pitch_movement >= $past(pitch_movement), "movement total went down")

endmodule

[tb/attitude_block_average_motion_unit_test.sv]
`timescale 1ns / 1ps

module attitude_block_average_motion_unit_test;
  import abam_pkg::*;

  localparam int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 1400;

  typedef struct packed {
    logic    fresh;
    angle_t  mean_roll;
    angle_t  mean_pitch;
    angle_t  mean_yaw;
    motion_t roll_motion;
    motion_t pitch_motion;
  } attitude_word_t;

  typedef enum int {
    SPREAD_IN_RANGE,
    SPREAD_FULL_WIDTH,
    SPREAD_HIGH_EDGE,
    SPREAD_LOW_EDGE,
    SPREAD_STEADY
  } spread_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  angle_t  roll_angle = '0;
  angle_t  pitch_angle = '0;
  angle_t  yaw_angle = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  logic    average_valid;
  angle_t  average_roll;
  angle_t  average_pitch;
  angle_t  average_yaw;
  motion_t roll_movement;
  motion_t pitch_movement;

  attitude_block_average_motion_unit #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .roll_angle(roll_angle),
    .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .average_valid(average_valid),
    .average_roll(average_roll),
    .average_pitch(average_pitch),
    .average_yaw(average_yaw),
    .roll_movement(roll_movement),
    .pitch_movement(pitch_movement)
  );

  always #5 clk = ~clk;

  // shadow of the averager state
  int             block_tally;
  int             roll_sum;
  int             pitch_sum;
  int             yaw_sum;
  int             last_roll_mag;
  int             last_pitch_mag;
  motion_t        roll_total;
  motion_t        pitch_total;
  angle_t         held_roll;
  angle_t         held_pitch;
  angle_t         held_yaw;

  attitude_word_t averages_due[$];
  int             fault_count = 0;
  int             cycle_count = 0;
  bit             steady_flow = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("attitude_block_average_motion_unit_test: done, errors");
      $finish;
    end
  end

  function automatic int magnitude(input angle_t a);
    int v;
    v = a;
    return (v < 0) ? -v : v;
  endfunction

  function automatic motion_t add_motion(input motion_t total, input int now, input int prior);
    longint step;
    longint sum;
    step = (now >= prior) ? now - prior : prior - now;
    sum = longint'(total) + step;
    return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : motion_t'(sum);
  endfunction

  function automatic void advance_attitude(input angle_t r, input angle_t p, input angle_t y);
    attitude_word_t w;
    w.fresh = 1'b0;
    if (block_tally < BLOCK_SAMPLES) begin
      roll_sum += int'(r);
      pitch_sum += int'(p);
      yaw_sum += int'(y);
      roll_total = add_motion(roll_total, magnitude(r), last_roll_mag);
      pitch_total = add_motion(pitch_total, magnitude(p), last_pitch_mag);
      last_roll_mag = magnitude(r);
      last_pitch_mag = magnitude(p);
      block_tally++;
    end else begin
      held_roll = angle_t'(roll_sum / BLOCK_SAMPLES);
      held_pitch = angle_t'(pitch_sum / BLOCK_SAMPLES);
      held_yaw = angle_t'(yaw_sum / BLOCK_SAMPLES);
      roll_sum = 0;
      pitch_sum = 0;
      yaw_sum = 0;
      block_tally = 0;
      w.fresh = 1'b1;
    end
    w.mean_roll = held_roll;
    w.mean_pitch = held_pitch;
    w.mean_yaw = held_yaw;
    w.roll_motion = roll_total;
    w.pitch_motion = pitch_total;
    averages_due.push_back(w);
  endfunction

  task automatic send_sample(input angle_t r, input angle_t p, input angle_t y);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    roll_angle <= r;
    pitch_angle <= p;
    yaw_angle <= y;
    do @(posedge clk); while (sample_stall);
    advance_attitude(r, p, y);
  endtask

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // result side
  initial begin
    int             hold;
    attitude_word_t want;
    wait (!rst);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      if (averages_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result word with nothing outstanding");
      end else begin
        want = averages_due.pop_front();
        compare_field("average_valid", want.fresh, average_valid);
        compare_field("average_roll", want.mean_roll, average_roll);
        compare_field("average_pitch", want.mean_pitch, average_pitch);
        compare_field("average_yaw", want.mean_yaw, average_yaw);
        compare_field("roll_movement", want.roll_motion, roll_movement);
        compare_field("pitch_movement", want.pitch_motion, pitch_movement);
      end
    end
  end

  // a full block of extremes, then a division word carrying junk
  task automatic test_extreme_block;
    angle_t rolls[BLOCK_SAMPLES] = '{-256, 255, -180, 180, 0, -1, 1, 0,
                                     -256, 255, -180, 180, -17, 100, -2, 0};
    angle_t pitches[BLOCK_SAMPLES] = '{255, -256, 180, -180, 0, 1, -1, 0,
                                       -256, 255, -180, 180, 3, -100, 2, -1};
    angle_t yaws[BLOCK_SAMPLES] = '{-180, 180, 0, -1, 1, -256, 255, 0,
                                    -256, 255, -180, 180, -5, 7, -9, 1};
    for (int i = 0; i < BLOCK_SAMPLES; i++)
      send_sample(rolls[i], pitches[i], yaws[i]);
    send_sample(255, -256, -1);
  endtask

  // averages must hold while the next block fills
  task automatic test_held_averages;
    send_sample(7, -7, 77);
    send_sample(-256, -256, -256);
    send_sample(255, 255, 255);
    send_sample(0, 0, 0);
    send_sample(-1, 1, -1);
  endtask

  function automatic angle_t draw_angle(input spread_t spread, input angle_t base);
    case (spread)
      SPREAD_IN_RANGE:   return angle_t'($urandom_range(0, 360) - 180);
      SPREAD_FULL_WIDTH: return angle_t'($urandom);
      SPREAD_HIGH_EDGE:  return ($urandom_range(0, 1) != 0) ? angle_t'(255) : angle_t'(180);
      SPREAD_LOW_EDGE:   return ($urandom_range(0, 1) != 0) ? angle_t'(-256) : angle_t'(-180);
      default:           return angle_t'(int'(base) + $urandom_range(0, 4) - 2);
    endcase
  endfunction

  task automatic test_random_blocks;
    spread_t spread;
    angle_t  base_r, base_p, base_y;
    int      pick;
    spread = SPREAD_IN_RANGE;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (block_tally == 0) begin
        pick = $urandom_range(0, 9);
        spread = (pick < 5) ? SPREAD_IN_RANGE :
                 (pick < 7) ? SPREAD_FULL_WIDTH :
                 (pick == 7) ? SPREAD_HIGH_EDGE :
                 (pick == 8) ? SPREAD_LOW_EDGE : SPREAD_STEADY;
        base_r = angle_t'($urandom_range(0, 360) - 180);
        base_p = angle_t'($urandom_range(0, 360) - 180);
        base_y = angle_t'($urandom_range(0, 360) - 180);
        steady_flow = ($urandom_range(0, 4) == 0);
      end
      if (block_tally == BLOCK_SAMPLES)
        send_sample(angle_t'($urandom), angle_t'($urandom), angle_t'($urandom));
      else
        send_sample(draw_angle(spread, base_r), draw_angle(spread, base_p),
                    draw_angle(spread, base_y));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    block_tally = 0;
    roll_sum = 0;
    pitch_sum = 0;
    yaw_sum = 0;
    last_roll_mag = 0;
    last_pitch_mag = 0;
    roll_total = '0;
    pitch_total = '0;
    held_roll = '0;
    held_pitch = '0;
    held_yaw = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_block();
    test_held_averages();
    test_random_blocks();
    sample_valid <= 1'b0;
    while (averages_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("attitude_block_average_motion_unit_test: done, clean");
    else
      $display("attitude_block_average_motion_unit_test: done, errors");
    $finish;
  end

endmodule
